>>> src/mqpd_pkg.sv
package mqpd_pkg;

    typedef enum logic [1:0] {
        ST_ADDED = 2'd0,
        ST_FULL  = 2'd1,
        ST_TAKEN = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

>>> src/mqpd_ctrl.sv
module mqpd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mqpd_pkg::dp_stat_t   stat,
    output mqpd_pkg::ctrl_cmd_t  cmd
);
    import mqpd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign cmd.capture  = (state_reg == S_IDLE) && s_valid;
    assign cmd.exec     = (state_reg == S_EXEC);
    assign cmd.load_out = (state_reg == S_DONE) && stat.out_free;

endmodule

>>> src/mqpd_datapath.sv
module mqpd_datapath #(
    parameter int NUM_QUEUES  = 32,
    parameter int QUEUE_DEPTH = 8,
    parameter int TAG_BITS    = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mqpd_pkg::ctrl_cmd_t  cmd,
    output mqpd_pkg::dp_stat_t   stat,
    input  logic                 s_operation,
    input  logic [4:0]           s_queue_index,
    input  logic [15:0]          s_entry_tag,
    input  logic                 s_urgent,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [15:0]          m_taken_tag,
    output logic                 m_taken_urgent
);
    import mqpd_pkg::*;

    localparam int QIW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SW    = PW + 1;
    localparam int LW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MW    = TAG_BITS + 1;

    // captured item
    logic                op_reg;
    logic [4:0]          qidx_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic                urg_reg;

    // per-queue circular buffer control
    logic [LW-1:0] len_reg  [NUM_QUEUES];
    logic [PW-1:0] head_reg [NUM_QUEUES];

    // entry storage, one row of QUEUE_DEPTH slots per queue
    logic [MW-1:0] mem [SLOTS];
    logic [MW-1:0] rd_reg;

    status_t status_reg;
    status_t status_next;

    logic          m_valid_reg;
    status_t       m_status_reg;
    logic [15:0]   m_tag_reg;
    logic          m_urg_reg;

    logic [QIW-1:0] q_sel;
    logic           in_range;
    logic [LW-1:0]  cur_len;
    logic [PW-1:0]  cur_head;
    logic           full;
    logic           empty;
    logic [SW-1:0]  tail_sum;
    logic [SW-1:0]  head_sum;
    logic [PW-1:0]  tail_ptr;
    logic [PW-1:0]  head_dec;
    logic [PW-1:0]  head_inc;
    logic [PW-1:0]  slot_ptr;
    logic [AW-1:0]  slot_addr;
    logic           do_add;
    logic           do_take;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_operation;
            qidx_reg <= s_queue_index;
            tag_reg  <= TAG_BITS'(s_entry_tag);
            urg_reg  <= s_urgent;
        end
    end

    assign q_sel    = QIW'(qidx_reg);
    assign in_range = (32'(qidx_reg) < NUM_QUEUES);
    assign cur_len  = len_reg[q_sel];
    assign cur_head = head_reg[q_sel];
    assign full     = (cur_len == LW'(QUEUE_DEPTH));
    assign empty    = (cur_len == '0);

    // wrap within the queue's row; sums stay below twice the depth
    assign tail_sum = SW'(cur_head) + SW'(cur_len);
    assign tail_ptr = (tail_sum >= SW'(QUEUE_DEPTH)) ? PW'(tail_sum - SW'(QUEUE_DEPTH))
                                                     : PW'(tail_sum);
    assign head_sum = SW'(cur_head) + SW'(1);
    assign head_inc = (head_sum >= SW'(QUEUE_DEPTH)) ? '0 : PW'(head_sum);
    assign head_dec = (cur_head == '0) ? PW'(QUEUE_DEPTH - 1) : cur_head - PW'(1);

    assign do_add  = (op_reg == OP_ADD) && in_range && !full;
    assign do_take = (op_reg == OP_TAKE) && in_range && !empty;

    always_comb begin
        if (op_reg == OP_ADD) begin
            status_next = do_add ? ST_ADDED : ST_FULL;
        end else begin
            status_next = do_take ? ST_TAKEN : ST_EMPTY;
        end
    end

    // urgent add goes in front of the head, regular add behind the tail
    assign slot_ptr  = do_take ? cur_head : (urg_reg ? head_dec : tail_ptr);
    assign slot_addr = AW'(32'(q_sel) * QUEUE_DEPTH) + AW'(slot_ptr);

    always_ff @(posedge aclk) begin
        if (cmd.exec && do_add) begin
            mem[slot_addr] <= {urg_reg, tag_reg};
        end
        if (cmd.exec && do_take) begin
            rd_reg <= mem[slot_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                len_reg[i]  <= '0;
                head_reg[i] <= '0;
            end
        end else if (cmd.exec) begin
            if (do_add) begin
                len_reg[q_sel] <= cur_len + LW'(1);
                if (urg_reg) begin
                    head_reg[q_sel] <= head_dec;
                end
            end else if (do_take) begin
                len_reg[q_sel]  <= cur_len - LW'(1);
                head_reg[q_sel] <= head_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status_reg <= status_reg;
            if (status_reg == ST_TAKEN) begin
                m_tag_reg <= 16'(rd_reg[TAG_BITS-1:0]);
                m_urg_reg <= rd_reg[MW-1];
            end else begin
                m_tag_reg <= '0;
                m_urg_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free  = !m_valid_reg || m_ready;
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_taken_tag    = m_tag_reg;
    assign m_taken_urgent = m_urg_reg;

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result loaded while output still held");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && in_range) |-> (cur_len <= LW'(QUEUE_DEPTH)))
        else $error("queue length above depth");

    a_add_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && do_add) |=> (len_reg[$past(q_sel)] == LW'($past(cur_len) + LW'(1))))
        else $error("accepted add did not grow the queue");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != ST_TAKEN)) |-> ((m_tag_reg == '0) && !m_urg_reg))
        else $error("nonzero entry fields on a non-take result");

endmodule

>>> src/multi_queue_priority_deque.sv
// Channel | Handshake          | Fields
// s_      | s_valid / s_ready  | operation, queue_index, entry_tag, urgent
// m_      | m_valid / m_ready  | status, taken_tag, taken_urgent
//
// Each item goes through accept, execute (one port of the slot memory, written
// for an add or read for a take, queue length and head pointer updated), deliver.
// Queues are circular rows in the slot memory; an urgent add moves the head back.
// aresetn (synchronous) clears lengths and head pointers; slot contents are not reset.
// The result sits in an output register; the next item is accepted while it waits,
// and only the deliver step stalls until that register frees up.
module multi_queue_priority_deque #(
    parameter int NUM_QUEUES  = 32,
    parameter int QUEUE_DEPTH = 8,
    parameter int TAG_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [4:0]  s_queue_index,
    input  logic [15:0] s_entry_tag,
    input  logic        s_urgent,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_taken_tag,
    output logic        m_taken_urgent
);
    import mqpd_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    mqpd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mqpd_datapath #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_operation    (s_operation),
        .s_queue_index  (s_queue_index),
        .s_entry_tag    (s_entry_tag),
        .s_urgent       (s_urgent),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_taken_tag    (m_taken_tag),
        .m_taken_urgent (m_taken_urgent)
    );

endmodule
